@@ hdl/tlaik_pkg.sv @@
// Shared constants, types and CORDIC angle table for the two-link arm IK pipeline.
package tlaik_pkg;

   localparam int LEN_W        = 14;
   localparam int POS_W        = 16;
   localparam int ANG_W        = 16;
   localparam int SQRT_STEPS   = 32;
   localparam int SQ_W         = 64;
   localparam int ND_W         = 34;
   localparam int VEC_W        = 45;
   localparam int ROT_W        = 34;
   localparam int ZR_W         = 33;
   localparam int CORDIC_STEPS = 24;
   localparam int NORM_STEPS   = 6;
   localparam int NORM_TOP     = 41;
   localparam int STEP_W       = $clog2(SQRT_STEPS);

   localparam logic [LEN_W-1:0] LINK_RESET = 14'd4096;
   localparam logic [ANG_W-1:0] ANG_PI     = 16'h8000;

   typedef logic [STEP_W-1:0]        step_type;
   typedef logic [SQ_W-1:0]          sq_word_type;
   typedef logic signed [ND_W-1:0]   nd_type;
   typedef logic signed [VEC_W-1:0]  vec_word_type;
   typedef logic signed [ROT_W-1:0]  rot_word_type;
   typedef logic signed [ZR_W-1:0]   zr_type;

   localparam rot_word_type CORDIC_START = 34'sd652032874;
   localparam zr_type       QUARTER_TURN = 33'sd1073741824;
   localparam zr_type       HALF_TURN    = 33'sd2147483648;

   localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
      32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   typedef enum logic [0:0] {
      CSR_UPPER_LINK = 1'b0,
      CSR_LOWER_LINK = 1'b1
   } csr_index_type;

   typedef struct packed {
      sq_word_type rem;
      sq_word_type root;
   } sqrt_state_type;

   typedef struct packed {
      vec_word_type x;
      vec_word_type y;
      logic [31:0]  z;
   } vec_state_type;

   typedef struct packed {
      rot_word_type x;
      rot_word_type y;
      zr_type       z;
   } rot_state_type;

endpackage

@@ hdl/tlaik_sqrt_cell.sv @@
// One restoring square-root step: decides one root bit and registers the partial result.
module tlaik_sqrt_cell (
   input  logic                       clock,
   input  logic                       adv,
   input  tlaik_pkg::step_type        step,
   input  tlaik_pkg::sqrt_state_type  st_i,
   output tlaik_pkg::sqrt_state_type  st_o
);

   logic [6:0]                pos;
   tlaik_pkg::sq_word_type    bit_val;
   tlaik_pkg::sq_word_type    trial;
   tlaik_pkg::sqrt_state_type st_in;
   tlaik_pkg::sqrt_state_type st_ff;

   always_comb begin
      pos     = 7'(tlaik_pkg::SQ_W - 2) - 7'({step, 1'b0});
      bit_val = tlaik_pkg::sq_word_type'(1) << pos;
      trial   = st_i.root + bit_val;
      if (st_i.rem >= trial) begin
         st_in.rem  = st_i.rem - trial;
         st_in.root = (st_i.root >> 1) + bit_val;
      end else begin
         st_in.rem  = st_i.rem;
         st_in.root = st_i.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign st_o = st_ff;

endmodule

@@ hdl/tlaik_vec_cell.sv @@
// One CORDIC vectoring step: drives y toward zero and accumulates the angle.
module tlaik_vec_cell (
   input  logic                      clock,
   input  logic                      adv,
   input  tlaik_pkg::step_type       step,
   input  tlaik_pkg::vec_state_type  st_i,
   output tlaik_pkg::vec_state_type  st_o
);

   tlaik_pkg::vec_word_type  xs;
   tlaik_pkg::vec_word_type  ys;
   tlaik_pkg::vec_state_type st_in;
   tlaik_pkg::vec_state_type st_ff;

   always_comb begin
      xs = st_i.x >>> step;
      ys = st_i.y >>> step;
      if (!st_i.y[tlaik_pkg::VEC_W-1]) begin
         st_in.x = st_i.x + ys;
         st_in.y = st_i.y - xs;
         st_in.z = st_i.z + tlaik_pkg::ATAN_TAB[step];
      end else begin
         st_in.x = st_i.x - ys;
         st_in.y = st_i.y + xs;
         st_in.z = st_i.z - tlaik_pkg::ATAN_TAB[step];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign st_o = st_ff;

endmodule

@@ hdl/tlaik_rot_cell.sv @@
// One CORDIC rotation step: turns (x, y) by the table angle toward the residual angle.
module tlaik_rot_cell (
   input  logic                      clock,
   input  logic                      adv,
   input  tlaik_pkg::step_type       step,
   input  tlaik_pkg::rot_state_type  st_i,
   output tlaik_pkg::rot_state_type  st_o
);

   tlaik_pkg::rot_word_type  xs;
   tlaik_pkg::rot_word_type  ys;
   tlaik_pkg::zr_type        ang;
   tlaik_pkg::rot_state_type st_in;
   tlaik_pkg::rot_state_type st_ff;

   always_comb begin
      xs  = st_i.x >>> step;
      ys  = st_i.y >>> step;
      ang = $signed({1'b0, tlaik_pkg::ATAN_TAB[step]});
      if (!st_i.z[tlaik_pkg::ZR_W-1]) begin
         st_in.x = st_i.x - ys;
         st_in.y = st_i.y + xs;
         st_in.z = st_i.z - ang;
      end else begin
         st_in.x = st_i.x + ys;
         st_in.y = st_i.y - xs;
         st_in.z = st_i.z + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign st_o = st_ff;

endmodule

@@ hdl/two_link_arm_inverse_kinematics.sv @@
// Top level: fully pipelined two-link planar arm inverse kinematics.
//
// One transaction enters per clock while the pipe advances; the pipe is 99 registers deep:
// products and sums, 32 square-root cells (one root bit each), flag checks, normalization
// and quarter-turn pre-rotation, 24 vectoring CORDIC cells, angle rounding and folding,
// 24 rotation CORDIC cells and link scaling and saturation, the last register of which is
// the output register. The two angles and their cosine/sine run in two parallel lanes. The
// whole pipe advances whenever the output register is empty or being taken; while a result
// is held the pipe stalls and req_ready is low. Link lengths come from csr registers that
// are read directly by the pipe and must only change while it is empty.
module two_link_arm_inverse_kinematics (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [tlaik_pkg::POS_W-1:0]  req_target_x,
   input  logic signed [tlaik_pkg::POS_W-1:0]  req_target_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tlaik_pkg::ANG_W-1:0]  rsp_shoulder_angle,
   output logic signed [tlaik_pkg::ANG_W-1:0]  rsp_second_link_angle,
   output logic signed [tlaik_pkg::POS_W-1:0]  rsp_elbow_x,
   output logic signed [tlaik_pkg::POS_W-1:0]  rsp_elbow_y,
   output logic signed [tlaik_pkg::POS_W-1:0]  rsp_tip_x,
   output logic signed [tlaik_pkg::POS_W-1:0]  rsp_tip_y,
   output logic                                rsp_unreachable,
   input  logic                                csr_write_enable,
   input  logic [0:0]                          csr_index,
   input  logic [tlaik_pkg::LEN_W-1:0]         csr_write_data
);

   localparam int POST_F   = 1 + 1 + tlaik_pkg::NORM_STEPS + 1 + tlaik_pkg::CORDIC_STEPS + 2
                             + tlaik_pkg::CORDIC_STEPS + 4;
   localparam int F_IDX    = 4 + tlaik_pkg::SQRT_STEPS;
   localparam int LAT      = F_IDX + POST_F;
   localparam int FL_LEN   = POST_F - 1;
   localparam int DZ_IDX   = 1 + 1 + tlaik_pkg::NORM_STEPS + tlaik_pkg::CORDIC_STEPS;
   localparam int R1_IDX   = F_IDX + DZ_IDX + 1;
   localparam int R2_IDX   = R1_IDX + 1;
   localparam int ANG_LEN  = 2 + tlaik_pkg::CORDIC_STEPS + 3;
   localparam int NG_LEN   = 1 + tlaik_pkg::CORDIC_STEPS;

   typedef struct packed {
      logic signed [31:0]  n0p;
      logic signed [31:0]  n1p;
      tlaik_pkg::nd_type   d0;
      tlaik_pkg::nd_type   d1;
      logic                neg;
   } front_side_type;

   typedef struct packed {
      logic       bad;
      logic [1:0] dz;
   } flag_type;

   typedef logic signed [49:0] prod_type;

   logic adv;
   logic [LAT-1:0] vld_ff;

   logic [tlaik_pkg::LEN_W-1:0] upper_len_ff;
   logic [tlaik_pkg::LEN_W-1:0] lower_len_ff;

   assign adv       = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_len_ff <= tlaik_pkg::LINK_RESET;
         lower_len_ff <= tlaik_pkg::LINK_RESET;
      end else if (csr_write_enable) begin
         unique case (tlaik_pkg::csr_index_type'(csr_index))
            tlaik_pkg::CSR_UPPER_LINK: upper_len_ff <= csr_write_data;
            tlaik_pkg::CSR_LOWER_LINK: lower_len_ff <= csr_write_data;
            default:                   upper_len_ff <= upper_len_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // ---------------- front: squares and cross products
   logic signed [14:0] l1s, l2s, dm;
   logic [14:0]        sp;

   logic signed [31:0] s1_xx_ff, s1_yy_ff;
   logic [29:0]        s1_dmsq_ff, s1_spsq_ff;
   logic signed [30:0] s1_l1x_ff, s1_l1y_ff, s1_l2x_ff, s1_l2y_ff;
   logic [27:0]        s1_l1sq_ff, s1_l2sq_ff;

   always_comb begin
      l1s = $signed({1'b0, upper_len_ff});
      l2s = $signed({1'b0, lower_len_ff});
      dm  = l1s - l2s;
      sp  = {1'b0, upper_len_ff} + {1'b0, lower_len_ff};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_xx_ff   <= 32'(req_target_x) * 32'(req_target_x);
         s1_yy_ff   <= 32'(req_target_y) * 32'(req_target_y);
         s1_dmsq_ff <= 30'(32'(dm) * 32'(dm));
         s1_spsq_ff <= 30'(sp) * 30'(sp);
         s1_l1x_ff  <= 31'(l1s) * 31'(req_target_x);
         s1_l1y_ff  <= 31'(l1s) * 31'(req_target_y);
         s1_l2x_ff  <= 31'(l2s) * 31'(req_target_x);
         s1_l2y_ff  <= 31'(l2s) * 31'(req_target_y);
         s1_l1sq_ff <= 28'(upper_len_ff) * 28'(upper_len_ff);
         s1_l2sq_ff <= 28'(lower_len_ff) * 28'(lower_len_ff);
      end
   end

   logic signed [32:0] s2_r2_ff;
   logic signed [28:0] s2_q_ff;
   logic [29:0]        s2_dmsq_ff, s2_spsq_ff;
   logic signed [30:0] s2_l1x_ff, s2_l1y_ff, s2_l2x_ff, s2_l2y_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_r2_ff   <= 33'(s1_xx_ff) + 33'(s1_yy_ff);
         s2_q_ff    <= $signed({1'b0, s1_l1sq_ff}) - $signed({1'b0, s1_l2sq_ff});
         s2_dmsq_ff <= s1_dmsq_ff;
         s2_spsq_ff <= s1_spsq_ff;
         s2_l1x_ff  <= s1_l1x_ff;
         s2_l1y_ff  <= s1_l1y_ff;
         s2_l2x_ff  <= s1_l2x_ff;
         s2_l2y_ff  <= s1_l2y_ff;
      end
   end

   tlaik_pkg::nd_type  s3_a_ff, s3_b_ff;
   front_side_type     s3_side_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_a_ff        <= 34'(s2_r2_ff) - $signed({4'b0, s2_dmsq_ff});
         s3_b_ff        <= $signed({4'b0, s2_spsq_ff}) - 34'(s2_r2_ff);
         s3_side_ff.d0  <= 34'(s2_q_ff) + (34'(s2_l1x_ff) <<< 1) + 34'(s2_r2_ff);
         s3_side_ff.d1  <= -34'(s2_q_ff) + (34'(s2_l2x_ff) <<< 1) + 34'(s2_r2_ff);
         s3_side_ff.n0p <= 32'(s2_l1y_ff) <<< 1;
         s3_side_ff.n1p <= 32'(s2_l2y_ff) <<< 1;
         s3_side_ff.neg <= 1'b0;
      end
   end

   // radicand sign follows from the factor signs; both negative cannot occur
   tlaik_pkg::sqrt_state_type s4_sq_ff;
   front_side_type            s4_side_ff;
   logic [62:0]               rad;

   assign rad = 63'(s3_a_ff[31:0]) * 63'(s3_b_ff[30:0]);

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_sq_ff.rem   <= 64'(rad);
         s4_sq_ff.root  <= '0;
         s4_side_ff.n0p <= s3_side_ff.n0p;
         s4_side_ff.n1p <= s3_side_ff.n1p;
         s4_side_ff.d0  <= s3_side_ff.d0;
         s4_side_ff.d1  <= s3_side_ff.d1;
         s4_side_ff.neg <= (s3_a_ff[tlaik_pkg::ND_W-1] != s3_b_ff[tlaik_pkg::ND_W-1]) &&
                           (s3_a_ff != '0) && (s3_b_ff != '0);
      end
   end

   // ---------------- square root chain
   tlaik_pkg::sqrt_state_type sq_st [tlaik_pkg::SQRT_STEPS+1];
   front_side_type            sq_side_ff [tlaik_pkg::SQRT_STEPS];

   assign sq_st[0] = s4_sq_ff;

   for (genvar k = 0; k < tlaik_pkg::SQRT_STEPS; k++) begin : g_sqrt
      tlaik_sqrt_cell u_cell (
         .clock (clock),
         .adv   (adv),
         .step  (tlaik_pkg::step_type'(k)),
         .st_i  (sq_st[k]),
         .st_o  (sq_st[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_side_ff[0] <= s4_side_ff;
         for (int k = 1; k < tlaik_pkg::SQRT_STEPS; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end
      end
   end

   // ---------------- numerators and special-case flags
   front_side_type    f_side;
   logic [31:0]       root;
   tlaik_pkg::nd_type n0, n1;
   tlaik_pkg::nd_type f_n_ff [2];
   tlaik_pkg::nd_type f_d_ff [2];
   flag_type          fl_in;
   flag_type          fl_ff [FL_LEN];

   always_comb begin
      f_side    = sq_side_ff[tlaik_pkg::SQRT_STEPS-1];
      root      = sq_st[tlaik_pkg::SQRT_STEPS].root[31:0];
      n0        = 34'(f_side.n0p) - $signed({2'b0, root});
      n1        = 34'(f_side.n1p) + $signed({2'b0, root});
      fl_in.bad = f_side.neg || (n0 == '0 && f_side.d0 == '0) || (n1 == '0 && f_side.d1 == '0);
      fl_in.dz  = {f_side.d1 == '0, f_side.d0 == '0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_n_ff[0] <= n0;
         f_n_ff[1] <= n1;
         f_d_ff[0] <= f_side.d0;
         f_d_ff[1] <= f_side.d1;
         fl_ff[0]  <= fl_in;
         for (int k = 1; k < FL_LEN; k++) begin
            fl_ff[k] <= fl_ff[k-1];
         end
      end
   end

   // ---------------- per-lane angle and position pipeline
   tlaik_pkg::vec_word_type  nm_n_ff [2][tlaik_pkg::NORM_STEPS+1];
   tlaik_pkg::vec_word_type  nm_d_ff [2][tlaik_pkg::NORM_STEPS+1];
   logic [tlaik_pkg::NORM_TOP-1:0] nm_m_ff [2][tlaik_pkg::NORM_STEPS+1];
   tlaik_pkg::vec_state_type vec_st [2][tlaik_pkg::CORDIC_STEPS+1];
   tlaik_pkg::rot_state_type rot_st [2][tlaik_pkg::CORDIC_STEPS+1];
   logic [tlaik_pkg::ANG_W-1:0] ang_ff [2][ANG_LEN];
   logic                     ng_ff [2][NG_LEN];
   tlaik_pkg::rot_word_type  m1_c_ff [2];
   tlaik_pkg::rot_word_type  m1_s_ff [2];
   prod_type                 m2_pc_ff [2];
   prod_type                 m2_ps_ff [2];
   logic signed [19:0]       m3_ec_ff [2];
   logic signed [19:0]       m3_es_ff [2];

   for (genvar l = 0; l < 2; l++) begin : g_lane
      tlaik_pkg::nd_type        an, ad;
      tlaik_pkg::vec_state_type pre;
      logic [31:0]              zr;
      logic [tlaik_pkg::ANG_W-1:0] a_round;
      tlaik_pkg::zr_type        zz;
      tlaik_pkg::rot_state_type r2_st;
      logic                     fold;
      logic signed [14:0]       len_s;
      prod_type                 pc_r, ps_r;

      // magnitudes and the larger of the two
      always_comb begin
         an = f_n_ff[l][tlaik_pkg::ND_W-1] ? -f_n_ff[l] : f_n_ff[l];
         ad = f_d_ff[l][tlaik_pkg::ND_W-1] ? -f_d_ff[l] : f_d_ff[l];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            nm_n_ff[l][0] <= tlaik_pkg::vec_word_type'(f_n_ff[l]);
            nm_d_ff[l][0] <= tlaik_pkg::vec_word_type'(f_d_ff[l]);
            nm_m_ff[l][0] <= (an > ad) ? tlaik_pkg::NORM_TOP'($unsigned(an))
                                       : tlaik_pkg::NORM_TOP'($unsigned(ad));
         end
      end

      // leading-zero normalization, largest shift first
      for (genvar k = 1; k <= tlaik_pkg::NORM_STEPS; k++) begin : g_norm
         localparam int P = 1 << (tlaik_pkg::NORM_STEPS - k);
         always_ff @(posedge clock) begin
            if (adv) begin
               if (nm_m_ff[l][k-1][tlaik_pkg::NORM_TOP-1 -: P] == '0) begin
                  nm_n_ff[l][k] <= nm_n_ff[l][k-1] <<< P;
                  nm_d_ff[l][k] <= nm_d_ff[l][k-1] <<< P;
                  nm_m_ff[l][k] <= nm_m_ff[l][k-1] << P;
               end else begin
                  nm_n_ff[l][k] <= nm_n_ff[l][k-1];
                  nm_d_ff[l][k] <= nm_d_ff[l][k-1];
                  nm_m_ff[l][k] <= nm_m_ff[l][k-1];
               end
            end
         end
      end

      // quarter-turn pre-rotation for a negative denominator
      always_comb begin
         pre.x = nm_d_ff[l][tlaik_pkg::NORM_STEPS];
         pre.y = nm_n_ff[l][tlaik_pkg::NORM_STEPS];
         pre.z = '0;
         if (nm_d_ff[l][tlaik_pkg::NORM_STEPS][tlaik_pkg::VEC_W-1]) begin
            if (!nm_n_ff[l][tlaik_pkg::NORM_STEPS][tlaik_pkg::VEC_W-1]) begin
               pre.x = nm_n_ff[l][tlaik_pkg::NORM_STEPS];
               pre.y = -nm_d_ff[l][tlaik_pkg::NORM_STEPS];
               pre.z = 32'h4000_0000;
            end else begin
               pre.x = -nm_n_ff[l][tlaik_pkg::NORM_STEPS];
               pre.y = nm_d_ff[l][tlaik_pkg::NORM_STEPS];
               pre.z = 32'hC000_0000;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            vec_st[l][0] <= pre;
         end
      end

      for (genvar k = 0; k < tlaik_pkg::CORDIC_STEPS; k++) begin : g_vec
         tlaik_vec_cell u_cell (
            .clock (clock),
            .adv   (adv),
            .step  (tlaik_pkg::step_type'(k)),
            .st_i  (vec_st[l][k]),
            .st_o  (vec_st[l][k+1])
         );
      end

      // round to 16-bit binary angle; zero denominator forces pi
      always_comb begin
         zr      = vec_st[l][tlaik_pkg::CORDIC_STEPS].z + 32'h0000_4000;
         a_round = fl_ff[DZ_IDX].dz[l] ? tlaik_pkg::ANG_PI : zr[30:15];
      end

      // fold into [-pi/2, pi/2] by a half turn, negate the result later
      always_comb begin
         zz   = $signed({ang_ff[l][0][tlaik_pkg::ANG_W-1], ang_ff[l][0], 16'h0000});
         fold = 1'b0;
         if (zz > tlaik_pkg::QUARTER_TURN) begin
            zz   = zz - tlaik_pkg::HALF_TURN;
            fold = 1'b1;
         end else if (zz < -tlaik_pkg::QUARTER_TURN) begin
            zz   = zz + tlaik_pkg::HALF_TURN;
            fold = 1'b1;
         end
         r2_st.x = tlaik_pkg::CORDIC_START;
         r2_st.y = '0;
         r2_st.z = zz;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ang_ff[l][0] <= a_round;
            for (int k = 1; k < ANG_LEN; k++) begin
               ang_ff[l][k] <= ang_ff[l][k-1];
            end
            rot_st[l][0] <= r2_st;
            ng_ff[l][0]  <= fold;
            for (int k = 1; k < NG_LEN; k++) begin
               ng_ff[l][k] <= ng_ff[l][k-1];
            end
         end
      end

      for (genvar k = 0; k < tlaik_pkg::CORDIC_STEPS; k++) begin : g_rot
         tlaik_rot_cell u_cell (
            .clock (clock),
            .adv   (adv),
            .step  (tlaik_pkg::step_type'(k)),
            .st_i  (rot_st[l][k]),
            .st_o  (rot_st[l][k+1])
         );
      end

      // scale by link length, round half up from 2^42 to 2^12
      always_comb begin
         len_s = (l == 0) ? $signed({1'b0, upper_len_ff}) : $signed({1'b0, lower_len_ff});
         pc_r  = m2_pc_ff[l] + 50'sd536870912;
         ps_r  = m2_ps_ff[l] + 50'sd536870912;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            m1_c_ff[l]  <= ng_ff[l][NG_LEN-1] ? -rot_st[l][tlaik_pkg::CORDIC_STEPS].x
                                              : rot_st[l][tlaik_pkg::CORDIC_STEPS].x;
            m1_s_ff[l]  <= ng_ff[l][NG_LEN-1] ? -rot_st[l][tlaik_pkg::CORDIC_STEPS].y
                                              : rot_st[l][tlaik_pkg::CORDIC_STEPS].y;
            m2_pc_ff[l] <= prod_type'(len_s) * prod_type'(m1_c_ff[l]);
            m2_ps_ff[l] <= prod_type'(len_s) * prod_type'(m1_s_ff[l]);
            m3_ec_ff[l] <= pc_r[49:30];
            m3_es_ff[l] <= ps_r[49:30];
         end
      end
   end

   // ---------------- output register
   function automatic logic signed [tlaik_pkg::POS_W-1:0] sat16(
      input logic signed [20:0] v
   );
      logic signed [tlaik_pkg::POS_W-1:0] r;
      if (v > 21'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -21'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[tlaik_pkg::POS_W-1:0];
      end
      return r;
   endfunction

   logic bad_out;
   assign bad_out = fl_ff[FL_LEN-1].bad;

   always_ff @(posedge clock) begin
      if (adv) begin
         if (bad_out) begin
            rsp_shoulder_angle    <= '0;
            rsp_second_link_angle <= '0;
            rsp_elbow_x           <= '0;
            rsp_elbow_y           <= '0;
            rsp_tip_x             <= '0;
            rsp_tip_y             <= '0;
            rsp_unreachable       <= 1'b1;
         end else begin
            rsp_shoulder_angle    <= $signed(ang_ff[0][ANG_LEN-1]);
            rsp_second_link_angle <= $signed(ang_ff[1][ANG_LEN-1]);
            rsp_elbow_x           <= sat16(21'(m3_ec_ff[0]));
            rsp_elbow_y           <= sat16(21'(m3_es_ff[0]));
            rsp_tip_x             <= sat16(21'(m3_ec_ff[0]) + 21'(m3_ec_ff[1]));
            rsp_tip_y             <= sat16(21'(m3_es_ff[0]) + 21'(m3_es_ff[1]));
            rsp_unreachable       <= 1'b0;
         end
      end
   end

   // ---------------- assertions
   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unreachable |->
         rsp_shoulder_angle == '0 && rsp_second_link_angle == '0 &&
         rsp_elbow_x == '0 && rsp_elbow_y == '0 && rsp_tip_x == '0 && rsp_tip_y == '0)
      else $error("unreachable transaction with nonzero fields");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while output stalled");

   a_zero_den_pi: assert property (@(posedge clock) disable iff (reset)
      vld_ff[R1_IDX] |->
         (!fl_ff[DZ_IDX+1].dz[0] || ang_ff[0][0] == tlaik_pkg::ANG_PI) &&
         (!fl_ff[DZ_IDX+1].dz[1] || ang_ff[1][0] == tlaik_pkg::ANG_PI))
      else $error("zero denominator did not give pi");

   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[R2_IDX] |->
         rot_st[0][0].z <= tlaik_pkg::QUARTER_TURN && rot_st[0][0].z >= -tlaik_pkg::QUARTER_TURN &&
         rot_st[1][0].z <= tlaik_pkg::QUARTER_TURN && rot_st[1][0].z >= -tlaik_pkg::QUARTER_TURN)
      else $error("rotation angle outside half circle after fold");

endmodule

@@ tb/sv/two_link_arm_inverse_kinematics_tb.sv @@
// Self-checking testbench for the two-link planar arm inverse kinematics pipeline.
module two_link_arm_inverse_kinematics_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [15:0] shoulder;
      logic signed [15:0] second;
      logic signed [15:0] elbow_x;
      logic signed [15:0] elbow_y;
      logic signed [15:0] tip_x;
      logic signed [15:0] tip_y;
      logic               unreachable;
   } arm_pose_type;

   typedef struct {
      bit                       is_write;
      tlaik_pkg::csr_index_type reg_index;
      logic [13:0]              length;
      logic signed [15:0]       x;
      logic signed [15:0]       y;
      bit                       known;
   } directed_row_type;

   localparam bit [31:0] ARC_STEP [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
      32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic signed [tlaik_pkg::POS_W-1:0]  req_target_x;
   logic signed [tlaik_pkg::POS_W-1:0]  req_target_y;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic signed [tlaik_pkg::ANG_W-1:0]  rsp_shoulder_angle;
   logic signed [tlaik_pkg::ANG_W-1:0]  rsp_second_link_angle;
   logic signed [tlaik_pkg::POS_W-1:0]  rsp_elbow_x;
   logic signed [tlaik_pkg::POS_W-1:0]  rsp_elbow_y;
   logic signed [tlaik_pkg::POS_W-1:0]  rsp_tip_x;
   logic signed [tlaik_pkg::POS_W-1:0]  rsp_tip_y;
   logic                                rsp_unreachable;
   logic                                csr_write_enable;
   logic [0:0]                          csr_index;
   logic [tlaik_pkg::LEN_W-1:0]         csr_write_data;

   arm_pose_type pending_poses[$];
   longint      upper_len;
   longint      lower_len;
   int          send_idle;
   int          recv_idle;
   int          error_count;
   int          targets_sent;
   int          poses_checked;
   int          unreachable_seen;

   two_link_arm_inverse_kinematics DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_target_x(req_target_x), .req_target_y(req_target_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_shoulder_angle(rsp_shoulder_angle), .rsp_second_link_angle(rsp_second_link_angle),
      .rsp_elbow_x(rsp_elbow_x), .rsp_elbow_y(rsp_elbow_y),
      .rsp_tip_x(rsp_tip_x), .rsp_tip_y(rsp_tip_y),
      .rsp_unreachable(rsp_unreachable),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit [63:0] floor_sqrt(bit [63:0] v);
      bit [63:0] r;
      bit [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2*atan2(n, d) as a 16-bit binary angle
   function automatic logic [15:0] half_angle(longint n, longint d);
      longint    x;
      longint    y;
      longint    nx;
      longint    xs;
      longint    ys;
      bit [63:0] m;
      bit [63:0] an;
      bit [63:0] ad;
      bit [31:0] z;
      z = 0;
      if (d == 0) return tlaik_pkg::ANG_PI;
      an = (n < 0) ? -n : n;
      ad = (d < 0) ? -d : d;
      m = (an > ad) ? an : ad;
      while (m < (64'd1 << 40)) begin
         m = m << 1;
         n = n * 2;
         d = d * 2;
      end
      x = d;
      y = n;
      if (x < 0) begin
         if (y >= 0) begin
            nx = y; y = -x; x = nx; z = 32'h40000000;
         end else begin
            nx = -y; y = x; x = nx; z = 32'hC0000000;
         end
      end
      for (int i = 0; i < 24; i++) begin
         ys = y >>> i;
         xs = x >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + ARC_STEP[i];
         end else begin
            x = x - ys; y = y + xs; z = z - ARC_STEP[i];
         end
      end
      z = z + 32'h4000;
      return z[30:15];
   endfunction

   task automatic rotate_unit(input logic [15:0] a, output longint c, output longint s);
      longint zz;
      longint x;
      longint y;
      longint xs;
      longint ys;
      bit     flip;
      zz = longint'({32'b0, a, 16'b0});
      x = 652032874;
      y = 0;
      flip = 0;
      if (zz >= 64'sd2147483648) zz = zz - 64'sd4294967296;
      if (zz > 64'sd1073741824) begin
         zz = zz - 64'sd2147483648; flip = 1;
      end else if (zz < -64'sd1073741824) begin
         zz = zz + 64'sd2147483648; flip = 1;
      end
      for (int i = 0; i < 24; i++) begin
         ys = y >>> i;
         xs = x >>> i;
         if (zz >= 0) begin
            x = x - ys; y = y + xs; zz = zz - longint'(ARC_STEP[i]);
         end else begin
            x = x + ys; y = y - xs; zz = zz + longint'(ARC_STEP[i]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic longint link_term(longint len, longint t);
      return (len * t + (longint'(1) << 29)) >>> 30;
   endfunction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   task automatic solve_arm(input logic signed [15:0] tx_in, input logic signed [15:0] ty_in,
                            output arm_pose_type p);
      longint     x, y, r2, dm, sp, rad, root, n0, d0, n1, d1, c, s, ex, ey;
      logic [15:0] a0;
      logic [15:0] a1;
      p = '{default: 0};
      x = tx_in;
      y = ty_in;
      r2 = x * x + y * y;
      dm = upper_len - lower_len;
      sp = upper_len + lower_len;
      rad = (r2 - dm * dm) * (sp * sp - r2);
      if (rad < 0) begin
         p.unreachable = 1;
         return;
      end
      root = longint'(floor_sqrt(rad));
      n0 = 2 * upper_len * y - root;
      d0 = upper_len * upper_len + 2 * upper_len * x - lower_len * lower_len + r2;
      n1 = 2 * lower_len * y + root;
      d1 = -upper_len * upper_len + 2 * lower_len * x + lower_len * lower_len + r2;
      if ((n0 == 0 && d0 == 0) || (n1 == 0 && d1 == 0)) begin
         p.unreachable = 1;
         return;
      end
      a0 = half_angle(n0, d0);
      a1 = half_angle(n1, d1);
      rotate_unit(a0, c, s);
      ex = link_term(upper_len, c);
      ey = link_term(upper_len, s);
      rotate_unit(a1, c, s);
      p.tip_x = clamp16(ex + link_term(lower_len, c));
      p.tip_y = clamp16(ey + link_term(lower_len, s));
      p.elbow_x = clamp16(ex);
      p.elbow_y = clamp16(ey);
      p.shoulder = a0;
      p.second = a1;
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name,
                  $signed(want), $signed(got));
         error_count++;
      end
   endtask

   always @(negedge clock) rsp_ready = ($urandom_range(99) >= recv_idle);

   always @(posedge clock) begin
      arm_pose_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_poses.size() == 0) begin
            $display("%0t: result with no transaction outstanding", $time);
            error_count++;
         end else begin
            want = pending_poses.pop_front();
            check_field("shoulder_angle", want.shoulder, rsp_shoulder_angle);
            check_field("second_link_angle", want.second, rsp_second_link_angle);
            check_field("elbow_x", want.elbow_x, rsp_elbow_x);
            check_field("elbow_y", want.elbow_y, rsp_elbow_y);
            check_field("tip_x", want.tip_x, rsp_tip_x);
            check_field("tip_y", want.tip_y, rsp_tip_y);
            check_field("unreachable", 16'(want.unreachable), 16'(rsp_unreachable));
            poses_checked++;
            if (rsp_unreachable) unreachable_seen++;
         end
      end
   end

   // Called at a falling edge; returns at a falling edge.
   task automatic send_target(logic signed [15:0] x, logic signed [15:0] y, bit known);
      arm_pose_type want;
      while ($urandom_range(99) < send_idle) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_target_x = x;
      req_target_y = y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (known) want = '{shoulder: 0, second: 0, elbow_x: 0, elbow_y: 0,
                          tip_x: 0, tip_y: 0, unreachable: 1};
      else solve_arm(x, y, want);
      pending_poses.push_back(want);
      targets_sent++;
      @(negedge clock);
   endtask

   task automatic write_link(tlaik_pkg::csr_index_type idx, logic [13:0] len);
      req_valid = 0;
      while (pending_poses.size() != 0) @(negedge clock);
      csr_write_enable = 1;
      csr_index = idx;
      csr_write_data = len;
      @(negedge clock);
      csr_write_enable = 0;
      if (idx == tlaik_pkg::CSR_UPPER_LINK) upper_len = len;
      else lower_len = len;
   endtask

   task automatic random_phase(int s_idle, int r_idle, int count);
      longint reach;
      logic signed [15:0] x;
      logic signed [15:0] y;
      send_idle = s_idle;
      recv_idle = r_idle;
      reach = upper_len + lower_len;
      if (reach > 32767) reach = 32767;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < 75) begin
            // mostly inside the workspace so the solver path is exercised
            x = 16'($signed($urandom_range(2 * reach)) - reach);
            y = 16'($signed($urandom_range(2 * reach)) - reach);
         end else begin
            x = 16'($urandom);
            y = 16'($urandom);
         end
         send_target(x, y, 0);
      end
   endtask

   directed_row_type corner_rows[] = '{
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, 16'sh7FFF, 16'sh7FFF, 1},
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, -16'sh8000, -16'sh8000, 1},
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, 0, 0, 1},
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, 4096, 4096, 0},
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, 8192, 0, 0},
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, -8192, 0, 0},
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, 0, -8191, 0},
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, -4096, 1, 0},
      '{1, tlaik_pkg::CSR_LOWER_LINK, 2048, 0, 0, 0},
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, -4096, -2048, 0},
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, -4096, 2048, 0},
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, 3000, -3000, 0},
      '{1, tlaik_pkg::CSR_UPPER_LINK, 16383, 0, 0, 0},
      '{1, tlaik_pkg::CSR_LOWER_LINK, 16383, 0, 0, 0},
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, 16'sh7FFF, 0, 0},
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, -16'sh8000, 0, 0},
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, 0, 16'sh7FFF, 0},
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, 23000, -23000, 0},
      '{1, tlaik_pkg::CSR_UPPER_LINK, 0, 0, 0, 0},
      '{1, tlaik_pkg::CSR_LOWER_LINK, 0, 0, 0, 0},
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, 0, 0, 0},
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, 5, -7, 0},
      '{1, tlaik_pkg::CSR_UPPER_LINK, 16383, 0, 0, 0},
      '{1, tlaik_pkg::CSR_LOWER_LINK, 1, 0, 0, 0},
      '{0, tlaik_pkg::CSR_UPPER_LINK, 0, -16383, 16383, 0}
   };

   initial begin
      #5_000_000;
      $display("two_link_arm_inverse_kinematics: mismatch");
      $finish;
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_target_x = 0;
      req_target_y = 0;
      rsp_ready = 0;
      csr_write_enable = 0;
      csr_index = tlaik_pkg::CSR_UPPER_LINK;
      csr_write_data = 0;
      upper_len = tlaik_pkg::LINK_RESET;
      lower_len = tlaik_pkg::LINK_RESET;
      send_idle = 20;
      recv_idle = 59;
      error_count = 0;
      targets_sent = 0;
      poses_checked = 0;
      unreachable_seen = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (corner_rows[i]) begin
         if (corner_rows[i].is_write)
            write_link(corner_rows[i].reg_index, corner_rows[i].length);
         else
            send_target(corner_rows[i].x, corner_rows[i].y, corner_rows[i].known);
      end

      write_link(tlaik_pkg::CSR_UPPER_LINK, 14'($urandom_range(2048, 9000)));
      write_link(tlaik_pkg::CSR_LOWER_LINK, 14'($urandom_range(2048, 9000)));
      random_phase(20, 59, 160);
      write_link(tlaik_pkg::CSR_UPPER_LINK, 14'($urandom_range(16383)));
      write_link(tlaik_pkg::CSR_LOWER_LINK, 14'($urandom_range(16383)));
      random_phase(20, 59, 60);
      write_link(tlaik_pkg::CSR_UPPER_LINK, 14'($urandom_range(1000, 6000)));
      write_link(tlaik_pkg::CSR_LOWER_LINK, 14'($urandom_range(1000, 6000)));
      random_phase(59, 20, 200);
      write_link(tlaik_pkg::CSR_UPPER_LINK, 16383);
      write_link(tlaik_pkg::CSR_LOWER_LINK, 16383);
      random_phase(0, 0, 80);
      write_link(tlaik_pkg::CSR_UPPER_LINK, 4096);
      write_link(tlaik_pkg::CSR_LOWER_LINK, 4096);
      random_phase(0, 0, 130);
      req_valid = 0;

      while (pending_poses.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      $display("Sent %0d targets over several link settings; %0d results checked.",
               targets_sent, poses_checked);
      $display("%0d results flagged unreachable; %0d field errors.",
               unreachable_seen, error_count);
      if (error_count == 0 && pending_poses.size() == 0)
         $display("two_link_arm_inverse_kinematics: match");
      else
         $display("two_link_arm_inverse_kinematics: mismatch");
      $finish;
   end

endmodule
